@@ src/utf8_to_ucs2_decoder_core_assert.svh @@
// assertion macros for the utf-8 to ucs-2 decoder
`ifndef UTF8_TO_UCS2_DECODER_CORE_ASSERT_SVH
`define UTF8_TO_UCS2_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define UTU_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define UTU_ASSERT(lbl, prop, msg) `UTU_ASSERT_CLK(lbl, clk, rst, prop, msg)
`else
`define UTU_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg)
`define UTU_ASSERT(lbl, prop, msg)
`endif
`endif

@@ src/utu_pkg.sv @@
// shared types and constants of the utf-8 to ucs-2 decoder
`default_nettype none
package utu_pkg;

  localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
  localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

  // most results one byte can cause: replacement, decoded lead, terminator
  localparam int PUSH_MAX       = 3;
  localparam int FIFO_DEPTH     = 4;
  localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW        = FIFO_AW + 1;
  localparam int FIFO_ROOM_MAX  = FIFO_DEPTH - PUSH_MAX;

  // one result item
  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_end;
  } res_t;

  // results of one byte, slot 0 first, n of them valid
  typedef struct packed {
    logic [1:0]          n;
    res_t [PUSH_MAX-1:0] slot;
  } push_t;

endpackage
`default_nettype wire

@@ src/utu_decode.sv @@
// per-byte decode logic and message state
`default_nettype none
module utu_decode
  import utu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  in_byte,
  input  wire logic        msg_last,
  input  wire logic [15:0] unit_limit,
  output push_t            push
);

  localparam logic [1:0] OWED_NONE = 2'd0;
  localparam logic [1:0] OWED_ONE  = 2'd1;
  localparam logic [1:0] OWED_TWO  = 2'd2;

  typedef struct packed {
    logic        emit;
    logic [15:0] unit;
    logic [1:0]  owed;
    logic        skip;
    logic        hit;
  } lead_t;

  // decode of a lead byte, room says the unit limit is not yet met
  function automatic lead_t lead_decode(input logic [7:0] b, input logic last,
                                        input logic room);
    lead_t r;
    r = '0;
    if (!room) begin
      r.hit = 1'b1;
    end else if (b <= 8'h7F) begin
      r.emit = 1'b1;
      r.unit = {8'd0, b};
    end else if (b <= 8'hDF) begin
      if (last) begin
        r.emit = 1'b1;
        r.unit = REPL_UNIT;
      end else begin
        r.owed = OWED_ONE;
      end
    end else if (b <= 8'hEF) begin
      if (last) begin
        r.emit = 1'b1;
        r.unit = REPL_UNIT;
      end else begin
        r.owed = OWED_TWO;
      end
    end else begin
      r.emit = 1'b1;
      r.unit = REPL_UNIT;
      r.skip = 1'b1;
    end
    return r;
  endfunction

  logic [7:0]  pending_lead, pending_lead_next;
  logic [1:0]  bytes_owed, bytes_owed_next;
  logic [5:0]  first_cont, first_cont_next;
  logic        skip_mode, skip_mode_next;
  logic [15:0] units_emitted, units_emitted_next;
  logic        limit_hit, limit_hit_next;

  lead_t       lead_a, lead_b;
  logic [15:0] cnt_inc;
  logic [1:0]  n_data;
  logic [15:0] d0, d1;

  // next message state and data units of this byte
  always_comb begin
    lead_a  = lead_decode(in_byte, msg_last, units_emitted < unit_limit);
    cnt_inc = units_emitted + 16'd1;
    lead_b  = lead_decode(in_byte, 1'b1, cnt_inc < unit_limit);

    pending_lead_next = pending_lead;
    bytes_owed_next   = bytes_owed;
    first_cont_next   = first_cont;
    skip_mode_next    = skip_mode;
    limit_hit_next    = limit_hit;
    n_data            = 2'd0;
    d0                = '0;
    d1                = '0;

    if (limit_hit) begin
      // rest of the message is dropped
    end else if (bytes_owed == OWED_TWO) begin
      first_cont_next = in_byte[5:0];
      bytes_owed_next = OWED_ONE;
      if (msg_last) begin
        // cut short: replacement, then the byte again as a final lead
        bytes_owed_next = OWED_NONE;
        n_data          = 2'd1;
        d0              = REPL_UNIT;
        if (lead_b.emit) begin
          n_data = 2'd2;
          d1     = lead_b.unit;
        end
        limit_hit_next = lead_b.hit;
      end
    end else if (bytes_owed == OWED_ONE) begin
      bytes_owed_next = OWED_NONE;
      n_data          = 2'd1;
      if (pending_lead <= 8'hDF) begin
        d0 = {5'd0, pending_lead[4:0], in_byte[5:0]};
      end else begin
        d0 = {pending_lead[3:0], first_cont, in_byte[5:0]};
      end
    end else if (skip_mode && in_byte[7:6] == 2'b10) begin
      // continuation after an unsupported lead
    end else begin
      skip_mode_next = lead_a.skip;
      limit_hit_next = lead_a.hit;
      if (lead_a.emit) begin
        n_data = 2'd1;
        d0     = lead_a.unit;
      end
      if (lead_a.owed != OWED_NONE) begin
        pending_lead_next = in_byte;
        bytes_owed_next   = lead_a.owed;
      end
    end

    units_emitted_next = units_emitted + {14'd0, n_data};

    if (msg_last) begin
      pending_lead_next  = '0;
      bytes_owed_next    = OWED_NONE;
      first_cont_next    = '0;
      skip_mode_next     = 1'b0;
      units_emitted_next = '0;
      limit_hit_next     = 1'b0;
    end
  end

  // result slots: data units first, terminator right after them
  always_comb begin
    push.n = step ? (n_data + {1'b0, msg_last}) : 2'd0;
    push.slot[0] = (n_data >= 2'd1) ? '{code_unit: d0, is_end: 1'b0}
                                    : '{code_unit: 16'd0, is_end: 1'b1};
    push.slot[1] = (n_data >= 2'd2) ? '{code_unit: d1, is_end: 1'b0}
                                    : '{code_unit: 16'd0, is_end: 1'b1};
    push.slot[2] = '{code_unit: 16'd0, is_end: 1'b1};
  end

  // message state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_lead  <= '0;
      bytes_owed    <= OWED_NONE;
      first_cont    <= '0;
      skip_mode     <= 1'b0;
      units_emitted <= '0;
      limit_hit     <= 1'b0;
    end else if (step) begin
      pending_lead  <= pending_lead_next;
      bytes_owed    <= bytes_owed_next;
      first_cont    <= first_cont_next;
      skip_mode     <= skip_mode_next;
      units_emitted <= units_emitted_next;
      limit_hit     <= limit_hit_next;
    end
  end

endmodule
`default_nettype wire

@@ src/utu_fifo.sv @@
// result queue taking up to three items a cycle and giving one
`default_nettype none
`include "utf8_to_ucs2_decoder_core_assert.svh"
module utu_fifo
  import utu_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  input  wire logic  pop,
  output res_t       head,
  output logic       valid,
  output logic       room
);

  res_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0] count;

  // status
  assign valid = (count != '0);
  assign room  = (count <= FIFO_CW'(FIFO_ROOM_MAX));
  assign head  = mem[rd_ptr];

  // storage write, slots in order from the write pointer
  always_ff @(posedge clk) begin
    for (int k = 0; k < PUSH_MAX; k++) begin
      if (FIFO_CW'(k) < {{(FIFO_CW-2){1'b0}}, push.n}) begin
        mem[wr_ptr + FIFO_AW'(k)] <= push.slot[k];
      end
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + FIFO_CW'(push.n) - FIFO_CW'(pop);
    end
  end

  `UTU_ASSERT(a_count_bound, count <= FIFO_CW'(FIFO_DEPTH), "result queue overfilled")
  `UTU_ASSERT(a_push_room, (push.n != 2'd0) |-> room, "push without room for three items")
  `UTU_ASSERT(a_pop_drains, (pop && push.n == 2'd0) |=> (count == $past(count) - FIFO_CW'(1)), "pop did not drain one item")

endmodule
`default_nettype wire

@@ src/utf8_to_ucs2_decoder_core.sv @@
// utf-8 to ucs-2 decoder top level: input register, decode stage, result queue
// the first result item of a byte passes the input register, is written into the result
//   queue and can be taken from its head when nothing stalls
// throughput: one byte per cycle while each byte gives at most one result and the
//   output is not held; after a byte giving several results the next byte waits
//   until the four-entry queue is down to one item; one item out a cycle sets the rate
// reset: synchronous rst clears message state and queue, unit_limit to 65535
`default_nettype none
module utf8_to_ucs2_decoder_core
  import utu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,   // unit_limit
  // byte stream in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  wire logic        s_axis_tlast,  // msg_last
  // code units out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [15:0] code_unit
  output logic             m_axis_tlast   // is_end
);

  logic [15:0] unit_limit;
  logic        in_vld;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        q_room;
  logic        fire;
  push_t       push;
  res_t        head;

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      unit_limit <= cfg_wdata;
    end
  end

  // input register
  assign fire          = in_vld && q_room;
  assign s_axis_tready = !in_vld || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // decode stage
  utu_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .step       (fire),
    .in_byte    (in_byte),
    .msg_last   (in_last),
    .unit_limit (unit_limit),
    .push       (push)
  );

  // result queue
  utu_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (m_axis_tvalid && m_axis_tready),
    .head  (head),
    .valid (m_axis_tvalid),
    .room  (q_room)
  );

  assign m_axis_tdata = head.code_unit;
  assign m_axis_tlast = head.is_end;

endmodule
`default_nettype wire

@@ tb/sv/tb_utf8_to_ucs2_decoder_core.sv @@
// testbench of the utf-8 to ucs-2 decoder: directed rows, then random messages over unit limits
module tb_utf8_to_ucs2_decoder_core;
  import utu_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_AFTER   = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 8;

  typedef enum logic {ROW_BYTE, ROW_LIMIT} row_kind_t;

  // one directed row: a byte, or a new unit limit
  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] val;
    logic        last;
    logic        fixed;
    logic [1:0]  n_fixed;
    res_t [2:0]  fixed_units;
  } stim_row_t;

  localparam res_t NO_RES   = '0;
  localparam res_t END_RES  = {16'h0000, 1'b1};
  localparam res_t REPL_RES = {REPL_UNIT, 1'b0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] in_byte
  logic        s_axis_tlast = 1'b0; // msg_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [15:0] code_unit
  logic        m_axis_tlast;        // is_end

  utf8_to_ucs2_decoder_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  // decoder state kept by the testbench
  logic [15:0] dec_limit;
  logic [7:0]  dec_lead;
  logic [1:0]  dec_owed;
  logic [7:0]  dec_cont;
  logic        dec_skip;
  logic [15:0] dec_count;
  logic        dec_drop;
  res_t        step_units[$];
  res_t        units_due[$];

  int src_idle_pct = 0;
  int bytes_sent = 0;
  int live_bytes = 0;
  int msgs_sent = 0;
  int limits_set = 0;
  int units_checked = 0;
  int errors = 0;
  int cycle_cnt = 0;

  function automatic void clear_msg();
    dec_lead  = '0;
    dec_owed  = '0;
    dec_cont  = '0;
    dec_skip  = 1'b0;
    dec_count = '0;
    dec_drop  = 1'b0;
  endfunction

  function automatic void put_unit(input logic [15:0] u, input logic e);
    res_t r;
    r.code_unit = u;
    r.is_end    = e;
    step_units = {step_units, r};
    if (!e) dec_count = dec_count + 16'd1;
  endfunction

  // limit check, then decode of a lead byte
  function automatic void open_lead(input logic [7:0] b, input logic last);
    if (dec_count >= dec_limit) begin
      dec_drop = 1'b1;
    end else if (b <= 8'h7F) begin
      put_unit({8'h00, b}, 1'b0);
    end else if (b <= 8'hEF && !last) begin
      dec_lead = b;
      dec_owed = (b <= 8'hDF) ? 2'd1 : 2'd2;
    end else begin
      // lead on the final byte, or a lead of 0xf0 and above
      put_unit(REPL_UNIT, 1'b0);
      if (b >= 8'hF0) dec_skip = 1'b1;
    end
  endfunction

  // units one accepted byte gives, left in step_units
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [15:0] u;
    step_units.delete();
    if (dec_drop) begin
      // rest of the message is dropped
    end else if (dec_owed == 2'd2) begin
      dec_cont = b;
      dec_owed = 2'd1;
      // three-byte sequence cut short: replacement, then the byte again as a lead
      if (last) begin
        dec_owed = 2'd0;
        put_unit(REPL_UNIT, 1'b0);
        open_lead(b, 1'b1);
      end
    end else if (dec_owed == 2'd1) begin
      if (dec_lead <= 8'hDF) u = {5'd0, dec_lead[4:0], b[5:0]};
      else u = {dec_lead[3:0], dec_cont[5:0], b[5:0]};
      dec_owed = 2'd0;
      put_unit(u, 1'b0);
    end else if (dec_skip && b[7:6] == 2'b10) begin
      // continuation after a long lead
    end else begin
      dec_skip = 1'b0;
      open_lead(b, last);
    end
    if (last) begin
      put_unit(16'h0000, 1'b1);
      clear_msg();
    end
  endfunction

  // mostly no gap, some short, a few long
  function automatic int idle_len(input int pct);
    int r;
    r = $urandom_range(0, 99);
    if (r >= pct) idle_len = 0;
    else if ($urandom_range(0, 19) == 0) idle_len = $urandom_range(8, 40);
    else idle_len = $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [31:0] rnd;
    rnd = $urandom;
    cont_byte = {2'b10, rnd[5:0]};
  endfunction

  function automatic stim_row_t pred_row(input logic [7:0] b, input logic last);
    stim_row_t t;
    t = '0;
    t.kind = ROW_BYTE;
    t.val  = {8'h00, b};
    t.last = last;
    pred_row = t;
  endfunction

  function automatic stim_row_t fixed_row(input logic [7:0] b, input logic last,
                                          input logic [1:0] n, input res_t r0,
                                          input res_t r1, input res_t r2);
    stim_row_t t;
    t = pred_row(b, last);
    t.fixed = 1'b1;
    t.n_fixed = n;
    t.fixed_units[0] = r0;
    t.fixed_units[1] = r1;
    t.fixed_units[2] = r2;
    fixed_row = t;
  endfunction

  function automatic stim_row_t limit_row(input logic [15:0] v);
    stim_row_t t;
    t = '0;
    t.kind = ROW_LIMIT;
    t.val  = v;
    limit_row = t;
  endfunction

  // offer one byte, wait for it to be taken, queue its units
  task automatic offer_byte(input logic [7:0] b, input logic last, input logic fixed,
                            input logic [1:0] n_fixed, input res_t [2:0] fixed_units);
    int gap;
    gap = idle_len(src_idle_pct);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (!dec_drop && !(dec_owed == 2'd0 && dec_skip && b[7:6] == 2'b10)) live_bytes++;
    bytes_sent++;
    if (last) msgs_sent++;
    decode_byte(b, last);
    if (fixed) begin
      for (int i = 0; i < n_fixed; i++) units_due = {units_due, fixed_units[i]};
    end else begin
      foreach (step_units[i]) units_due = {units_due, step_units[i]};
    end
  endtask

  // new unit limit once the decoder has gone quiet
  task automatic write_limit(input logic [15:0] v);
    s_axis_tvalid <= 1'b0;
    while (units_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dec_limit = v;
    limits_set++;
  endtask

  // mostly well-formed characters with random content, some noise, cut at a random length
  task automatic send_random_message();
    logic [7:0] seq[$];
    logic [7:0] b;
    int len;
    int r;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    case ($urandom_range(0, 3))
      0: src_idle_pct = 0;
      1: src_idle_pct = 10;
      2: src_idle_pct = 30;
      default: src_idle_pct = 60;
    endcase
    while (seq.size() < len) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        b = 8'($urandom_range(0, 127));
        seq = {seq, b};
      end else if (r < 60) begin
        b = 8'($urandom_range(128, 223));
        seq = {seq, b};
        seq = {seq, cont_byte()};
      end else if (r < 80) begin
        b = 8'($urandom_range(224, 239));
        seq = {seq, b};
        repeat (2) seq = {seq, cont_byte()};
      end else if (r < 88) begin
        b = 8'($urandom_range(240, 255));
        seq = {seq, b};
        repeat ($urandom_range(0, 3)) seq = {seq, cont_byte()};
      end else begin
        b = 8'($urandom);
        seq = {seq, b};
      end
    end
    for (int k = 0; k < len; k++) offer_byte(seq[k], k == len - 1, 1'b0, 2'd0, '0);
  endtask

  // result side: compare each item with the oldest expected unit
  always @(posedge clk) begin
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (units_due.size() == 0) begin
        $display("%0t: unit %h end %b arrived with none expected",
                 $time, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = units_due.pop_front();
        if (m_axis_tdata !== want.code_unit) begin
          $display("%0t: code_unit expected %h got %h", $time, want.code_unit, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== want.is_end) begin
          $display("%0t: is_end expected %b got %b", $time, want.is_end, m_axis_tlast);
          errors++;
        end
        units_checked <= units_checked + 1;
      end
    end
  end

  // result side ready: random stalls plus one long hold-off
  int  sink_pct = 20;
  int  sink_gap = 0;
  int  hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && units_checked >= HOLD_AFTER) begin
      // long hold-off so the result queue fills and the input backs up
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (sink_gap > 0) begin
      m_axis_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 63) == 0) sink_pct <= 15 * $urandom_range(0, 3);
      sink_gap <= idle_len(sink_pct);
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d units still expected", cycle_cnt, units_due.size());
    $display("Test completed with failures");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    stim_row_t   rows[$];
    logic [15:0] phase_limit[PHASES];
    int          phase_items[PHASES];
    int          goal;

    clear_msg();
    dec_limit = LIMIT_RESET;

    // default limit: extremes, every sequence length, long lead and skipping
    rows = {rows, fixed_row(8'h00, 1'b0, 2'd1, {16'h0000, 1'b0}, NO_RES, NO_RES)};
    rows = {rows, fixed_row(8'h7F, 1'b0, 2'd1, {16'h007F, 1'b0}, NO_RES, NO_RES)};
    rows = {rows, pred_row(8'hDF, 1'b0)};
    rows = {rows, pred_row(8'hBF, 1'b0)};
    rows = {rows, pred_row(8'hEF, 1'b0)};
    rows = {rows, pred_row(8'hBF, 1'b0)};
    rows = {rows, pred_row(8'hBF, 1'b0)};
    rows = {rows, fixed_row(8'hF0, 1'b0, 2'd1, REPL_RES, NO_RES, NO_RES)};
    rows = {rows, fixed_row(8'h9F, 1'b0, 2'd0, NO_RES, NO_RES, NO_RES)};
    rows = {rows, pred_row(8'h41, 1'b0)};
    // three-byte sequence cut short at message end
    rows = {rows, pred_row(8'hE2, 1'b0)};
    rows = {rows, fixed_row(8'h82, 1'b1, 2'd3, REPL_RES, REPL_RES, END_RES)};
    // lead on the final byte
    rows = {rows, fixed_row(8'hC2, 1'b1, 2'd2, REPL_RES, END_RES, NO_RES)};
    // limit reached, then raised in the middle of the message
    rows = {rows, limit_row(16'd1)};
    rows = {rows, pred_row(8'h41, 1'b0)};
    rows = {rows, fixed_row(8'h42, 1'b0, 2'd0, NO_RES, NO_RES, NO_RES)};
    rows = {rows, limit_row(16'hFFFF)};
    rows = {rows, fixed_row(8'h43, 1'b0, 2'd0, NO_RES, NO_RES, NO_RES)};
    rows = {rows, fixed_row(8'hFF, 1'b1, 2'd1, END_RES, NO_RES, NO_RES)};
    // zero limit: terminator only
    rows = {rows, limit_row(16'd0)};
    rows = {rows, fixed_row(8'h00, 1'b1, 2'd1, END_RES, NO_RES, NO_RES)};
    // open sequence completes, the next lead meets the limit
    rows = {rows, limit_row(16'd2)};
    rows = {rows, pred_row(8'hC3, 1'b0)};
    rows = {rows, pred_row(8'hA9, 1'b0)};
    rows = {rows, pred_row(8'hE2, 1'b0)};
    rows = {rows, pred_row(8'h82, 1'b0)};
    rows = {rows, pred_row(8'hAC, 1'b0)};
    rows = {rows, fixed_row(8'h80, 1'b1, 2'd1, END_RES, NO_RES, NO_RES)};

    phase_limit = '{LIMIT_RESET, 16'd3, 16'd0, 16'd1, 16'($urandom_range(2, 6)),
                    16'($urandom_range(0, 65535)), 16'd2, LIMIT_RESET};
    phase_items = '{70, 50, 30, 40, 50, 70, 50, 60};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct = 30;
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_LIMIT) write_limit(rows[i].val);
      else offer_byte(rows[i].val[7:0], rows[i].last, rows[i].fixed, rows[i].n_fixed,
                      rows[i].fixed_units);
    end

    // random messages under each unit limit
    for (int p = 0; p < PHASES; p++) begin
      write_limit(phase_limit[p]);
      goal = bytes_sent + phase_items[p];
      while (bytes_sent < goal) send_random_message();
    end

    s_axis_tvalid <= 1'b0;
    while (units_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes (%0d decoded) in %0d messages under %0d unit limit settings",
             bytes_sent, live_bytes, msgs_sent, limits_set);
    $display("checked %0d code units in %0d cycles, %0d mismatches",
             units_checked, cycle_cnt, errors);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/utu_pkg.sv
src/utu_decode.sv
src/utu_fifo.sv
src/utf8_to_ucs2_decoder_core.sv
tb/sv/tb_utf8_to_ucs2_decoder_core.sv
